/* design/rff_pkg.sv */
// rff_pkg: widths, latencies, kind codes, cordic angle table and the side-band struct
// used by region_force_field and its cordic and divider pipelines.
// No dependencies.
package rff_pkg;

	// field widths
	localparam int COORD_W       = 32;
	localparam int MAG_W         = 31;   // offset magnitude on the active path
	localparam int SQR_W         = 62;   // square of a magnitude
	localparam int REM_W         = 63;   // sum of squares, divider remainder
	localparam int QUO_W         = 32;   // quotient of the force scaling
	localparam int FRAC_BITS_DEF = 16;

	// cordic
	localparam int ANG_BITS      = 30;
	localparam int CORDIC_STEPS  = 30;
	localparam int CW            = 35;   // cordic datapath width
	localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
	localparam logic signed [CW-1:0] PI_Q30 = 35'sd3373259426;

	localparam logic signed [CW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159, 35'sd67021687,
		35'sd33543516,  35'sd16775851,  35'sd8388437,   35'sd4194283,   35'sd2097149,
		35'sd1048576,   35'sd524288,    35'sd262144,    35'sd131072,    35'sd65536,
		35'sd32768,     35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
		35'sd1024,      35'sd512,       35'sd256,       35'sd128,       35'sd64,
		35'sd32,        35'sd16,        35'sd8,         35'sd4,         35'sd2
	};

	// pipeline latencies, counted in register stages
	localparam int CORDIC_LAT = 2 + CORDIC_STAGES + 1;
	localparam int SQ_LAT     = (MAG_W + 1) / 2;
	localparam int DIV_LAT    = QUO_W / 2;

	// object kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_BOX  = 2'd1;
	localparam logic [1:0] KIND_DISC = 2'd2;

	// per transaction data that rides alongside the long arithmetic
	typedef struct packed {
		logic                      is_box;
		logic                      box_in;
		logic                      is_disc;
		logic                      rad_ok;
		logic                      zero;
		logic                      neg_x;
		logic                      neg_y;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic        [MAG_W-1:0]   mdx;
		logic        [MAG_W-1:0]   mdy;
		logic        [COORD_W-1:0] mst;
	} side_t;

endpackage

/* design/rff_cordic.sv */
// rff_cordic: pipelined atan2 of an offset, normalize then vectoring cordic then rounding.
// Depends on rff_pkg. One transaction per cycle.
module rff_cordic #(
	parameter int FRAC_BITS = rff_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic signed [rff_pkg::COORD_W-1:0]  dx,
	input  logic signed [rff_pkg::COORD_W-1:0]  dy,
	output logic signed [rff_pkg::CW-1:0]       angle
);
	import rff_pkg::*;

	localparam int SH = ANG_BITS - FRAC_BITS;
	localparam logic [CW-1:0] HALF = CW'(1) << (SH - 1);
	localparam logic signed [CW-1:0] PI_RND = (PI_Q30 + $signed(HALF)) >>> SH;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cstate_t;

	// shift right truncating toward zero
	function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
		input int s);
		logic signed [CW-1:0] n;
		n = -v;
		return v[CW-1] ? -(n >>> s) : (v >>> s);
	endfunction

	function automatic cstate_t cstep(input cstate_t c, input int i);
		cstate_t r;
		if (c.y > 0) begin
			r.x = c.x + shr_tz(c.y, i);
			r.y = c.y - shr_tz(c.x, i);
			r.z = c.z + ATAN_Q30[i];
		end else begin
			r.x = c.x - shr_tz(c.y, i);
			r.y = c.y + shr_tz(c.x, i);
			r.z = c.z - ATAN_Q30[i];
		end
		return r;
	endfunction

	// normalize, first half: shifts of 16 and 8
	logic signed [COORD_W-1:0] x_n1, y_n1;
	logic [COORD_W-1:0] m_n1;
	logic yz_n1;
	logic signed [COORD_W-1:0] x_n0, y_n0;
	logic [COORD_W-1:0] m_n0;

	always_comb begin
		logic [COORD_W-1:0] ax, ay;
		ax = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
		ay = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
		m_n0 = ax | ay;
		x_n0 = dx;
		y_n0 = dy;
		if (m_n0 < (COORD_W'(1) << 14)) begin
			x_n0 = x_n0 <<< 16; y_n0 = y_n0 <<< 16; m_n0 = m_n0 << 16;
		end
		if (m_n0 < (COORD_W'(1) << 22)) begin
			x_n0 = x_n0 <<< 8; y_n0 = y_n0 <<< 8; m_n0 = m_n0 << 8;
		end
	end

	always_ff @(posedge clk) begin
		x_n1  <= x_n0;
		y_n1  <= y_n0;
		m_n1  <= m_n0;
		yz_n1 <= (dy == '0);
	end

	// normalize, second half: shifts of 4, 2, 1, then fold the left half plane
	cstate_t c_n1;
	logic xn_n1;

	always_comb begin
		logic signed [COORD_W-1:0] xs, ys;
		logic [COORD_W-1:0] ms;
		xs = x_n1; ys = y_n1; ms = m_n1;
		if (ms < (COORD_W'(1) << 26)) begin
			xs = xs <<< 4; ys = ys <<< 4; ms = ms << 4;
		end
		if (ms < (COORD_W'(1) << 28)) begin
			xs = xs <<< 2; ys = ys <<< 2; ms = ms << 2;
		end
		if (ms < (COORD_W'(1) << 29)) begin
			xs = xs <<< 1; ys = ys <<< 1;
		end
		xn_n1 = x_n1[COORD_W-1];
		c_n1.x = CW'(xs);
		c_n1.y = CW'(ys);
		c_n1.z = '0;
		if (xn_n1) begin
			c_n1.z = ys[COORD_W-1] ? -PI_Q30 : PI_Q30;
			c_n1.x = -CW'(xs);
			c_n1.y = -CW'(ys);
		end
	end

	cstate_t c_s [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0] yz_s, xn_s;

	always_ff @(posedge clk) begin
		c_s[0]  <= c_n1;
		yz_s[0] <= yz_n1;
		xn_s[0] <= xn_n1;
	end

	// two micro-rotations per stage
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		cstate_t c_a, c_b;
		assign c_a = cstep(c_s[g], 2 * g);
		assign c_b = cstep(c_a, 2 * g + 1);
		always_ff @(posedge clk) begin
			c_s[g+1]  <= c_b;
			yz_s[g+1] <= yz_s[g];
			xn_s[g+1] <= xn_s[g];
		end
	end

	// round to the output fraction, ties away from zero; exact axis cases
	logic signed [CW-1:0] ang_rnd;

	always_comb begin
		logic [CW-1:0] mz, rm;
		mz = c_s[CORDIC_STAGES].z[CW-1] ? CW'(-c_s[CORDIC_STAGES].z)
			: CW'(c_s[CORDIC_STAGES].z);
		rm = (mz + HALF) >> SH;
		ang_rnd = c_s[CORDIC_STAGES].z[CW-1] ? -$signed(rm) : $signed(rm);
		if (yz_s[CORDIC_STAGES])
			ang_rnd = xn_s[CORDIC_STAGES] ? PI_RND : '0;
	end

	always_ff @(posedge clk) begin
		angle <= ang_rnd;
	end

endmodule

/* design/rff_div.sv */
// rff_div: pipelined restoring divider, two quotient bits per stage.
// Depends on rff_pkg. Needs dividend < divisor * 2^QUO_W.
module rff_div (
	input  logic                         clk,
	input  logic [rff_pkg::REM_W-1:0]    dividend,
	input  logic [rff_pkg::MAG_W-1:0]    divisor,
	output logic [rff_pkg::QUO_W-1:0]    quotient
);
	import rff_pkg::*;

	logic [REM_W-1:0] rem_s [0:DIV_LAT];
	logic [MAG_W-1:0] dvs_s [0:DIV_LAT];
	logic [QUO_W-1:0] quo_s [0:DIV_LAT];

	assign rem_s[0] = dividend;
	assign dvs_s[0] = divisor;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
		localparam int HI = QUO_W - 1 - 2 * g;
		logic [REM_W-1:0] r0, r1, t0, t1;
		logic [QUO_W-1:0] q1;

		// subtract the shifted divisor where it fits, high bit then low bit
		always_comb begin
			t0 = {{(REM_W - MAG_W){1'b0}}, dvs_s[g]} << HI;
			t1 = {{(REM_W - MAG_W){1'b0}}, dvs_s[g]} << (HI - 1);
			q1 = quo_s[g];
			r0 = rem_s[g];
			if (r0 >= t0) begin
				r0 = r0 - t0;
				q1[HI] = 1'b1;
			end
			r1 = r0;
			if (r1 >= t1) begin
				r1 = r1 - t1;
				q1[HI-1] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= r1;
			dvs_s[g+1] <= dvs_s[g];
			quo_s[g+1] <= q1;
		end
	end

	assign quotient = quo_s[DIV_LAT];

endmodule

/* design/region_force_field.sv */
// region_force_field: force of one box or annular wedge object on a point.
// Depends on rff_pkg, rff_cordic (wedge angle) and rff_div (force scaling).
//
// Usage
//   A transaction is accepted at a rising edge with start high and busy low.
//   busy never rises: the block takes a new transaction in every cycle.
//   Every transaction gives exactly one result: push_x, push_y and hit are
//   shown for one cycle with done high, in the order the transactions came.
//   A transaction passes the offset, square, length, square root, product,
//   divider and result registers; done is high in the cycle after the edge
//   that loads the result registers. Throughput is one transaction per
//   cycle. The long path is the 16 stage square root of the offset length
//   (two root bits a stage, one in the last) followed by the 16 stage
//   divider that scales the offset to the strength (two quotient bits a
//   stage); the cordic angle runs beside the root in 18 stages.
//   The receiver cannot stall, so the pipeline never holds.
//   Reset clears the valid bits and done; transactions in flight are dropped.
//   Box: hit when strictly inside, push is the box force. Wedge: hit inside
//   the annulus unless the angle falls in the excluded window, push is the
//   offset scaled to the strength and saturated. Otherwise push is zero.
module region_force_field #(
	parameter int FRAC_BITS = rff_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic signed [rff_pkg::COORD_W-1:0] pos_x,
	input  logic signed [rff_pkg::COORD_W-1:0] pos_y,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_a_x,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_a_y,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_b_x,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_b_y,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_c_x,
	input  logic signed [rff_pkg::COORD_W-1:0] shape_c_y,
	input  logic signed [rff_pkg::COORD_W-1:0] strength,
	output logic                               done,
	output logic signed [rff_pkg::COORD_W-1:0] push_x,
	output logic signed [rff_pkg::COORD_W-1:0] push_y,
	output logic                               hit
);
	import rff_pkg::*;

	localparam int OUT_TAP = SQ_LAT + 1 + DIV_LAT;
	localparam int ANG_N   = OUT_TAP - CORDIC_LAT;
	localparam int LAT     = 3 + OUT_TAP + 1;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] root;
	} sq_t;

	// one root bit of the digit recurrence
	function automatic sq_t sq_step(input sq_t s, input int i);
		sq_t r;
		logic [REM_W-1:0] t;
		t = ({{(REM_W - MAG_W){1'b0}}, s.root} << (i + 1)) + (REM_W'(1) << (2 * i));
		r = s;
		if (s.rem >= t) begin
			r.rem = s.rem - t;
			r.root = s.root | (MAG_W'(1) << i);
		end
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] sat(input logic [QUO_W-1:0] q, input logic neg);
		logic [QUO_W-1:0] lim;
		lim = {1'b1, {(QUO_W - 1){1'b0}}};
		if (neg)
			return (q > lim) ? lim : COORD_W'(-q);
		return (q >= lim) ? {1'b0, {(COORD_W - 1){1'b1}}} : q;
	endfunction

	assign busy = 1'b0;

	// stage 1: offsets and box test
	logic [OUT_TAP+2:0] vld;
	logic signed [COORD_W:0] dx_s1, dy_s1;
	logic is_box_s1, is_disc_s1, box_in_s1;
	logic signed [COORD_W-1:0] bx_s1, by_s1, cx_s1, cy_s1, st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[OUT_TAP+1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		dx_s1      <= {pos_x[COORD_W-1], pos_x} - {shape_a_x[COORD_W-1], shape_a_x};
		dy_s1      <= {pos_y[COORD_W-1], pos_y} - {shape_a_y[COORD_W-1], shape_a_y};
		is_box_s1  <= (kind == KIND_BOX);
		is_disc_s1 <= (kind == KIND_DISC);
		box_in_s1  <= (pos_x > shape_a_x) && (pos_x < shape_b_x) &&
			(pos_y > shape_a_y) && (pos_y < shape_b_y);
		bx_s1      <= shape_b_x;
		by_s1      <= shape_b_y;
		cx_s1      <= shape_c_x;
		cy_s1      <= shape_c_y;
		st_s1      <= strength;
	end

	// stage 2: magnitudes and squares
	logic [COORD_W:0] adx, ady;
	logic [MAG_W-1:0] mdx_s2, mdy_s2;
	logic [SQR_W-1:0] dx2_s2, dy2_s2, rin2_s2, rout2_s2;
	logic big_s2, bx_neg_s2, by_pos_s2, sdx_s2, sdy_s2, is_box_s2, is_disc_s2, box_in_s2;
	logic signed [COORD_W-1:0] dx_s2, dy_s2, cx_s2, cy_s2, st_s2;

	assign adx = dx_s1[COORD_W] ? (COORD_W + 1)'(-dx_s1) : (COORD_W + 1)'(dx_s1);
	assign ady = dy_s1[COORD_W] ? (COORD_W + 1)'(-dy_s1) : (COORD_W + 1)'(dy_s1);

	always_ff @(posedge clk) begin
		mdx_s2     <= adx[MAG_W-1:0];
		mdy_s2     <= ady[MAG_W-1:0];
		big_s2     <= (|adx[COORD_W:MAG_W]) | (|ady[COORD_W:MAG_W]);
		dx2_s2     <= adx[MAG_W-1:0] * adx[MAG_W-1:0];
		dy2_s2     <= ady[MAG_W-1:0] * ady[MAG_W-1:0];
		rin2_s2    <= bx_s1[MAG_W-1:0] * bx_s1[MAG_W-1:0];
		rout2_s2   <= by_s1[MAG_W-1:0] * by_s1[MAG_W-1:0];
		bx_neg_s2  <= bx_s1[COORD_W-1];
		by_pos_s2  <= !by_s1[COORD_W-1] && (by_s1 != '0);
		sdx_s2     <= dx_s1[COORD_W];
		sdy_s2     <= dy_s1[COORD_W];
		dx_s2      <= dx_s1[COORD_W-1:0];
		dy_s2      <= dy_s1[COORD_W-1:0];
		is_box_s2  <= is_box_s1;
		is_disc_s2 <= is_disc_s1;
		box_in_s2  <= box_in_s1;
		cx_s2      <= cx_s1;
		cy_s2      <= cy_s1;
		st_s2      <= st_s1;
	end

	// stage 3: length squared and annulus test
	logic [REM_W-1:0] lo;
	logic [REM_W-1:0] lo_s3;
	logic signed [COORD_W-1:0] dx_s3, dy_s3;
	side_t sb [0:OUT_TAP];

	assign lo = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk) begin
		lo_s3         <= lo;
		dx_s3         <= dx_s2;
		dy_s3         <= dy_s2;
		sb[0].is_box  <= is_box_s2;
		sb[0].box_in  <= box_in_s2;
		sb[0].is_disc <= is_disc_s2;
		sb[0].rad_ok  <= !big_s2 && (bx_neg_s2 || lo > {1'b0, rin2_s2}) &&
			by_pos_s2 && (lo < {1'b0, rout2_s2});
		sb[0].zero    <= (mdx_s2 == '0) && (mdy_s2 == '0);
		sb[0].neg_x   <= sdx_s2 ^ st_s2[COORD_W-1];
		sb[0].neg_y   <= sdy_s2 ^ st_s2[COORD_W-1];
		sb[0].cx      <= cx_s2;
		sb[0].cy      <= cy_s2;
		sb[0].mdx     <= mdx_s2;
		sb[0].mdy     <= mdy_s2;
		sb[0].mst     <= st_s2[COORD_W-1] ? COORD_W'(-st_s2) : COORD_W'(st_s2);
	end

	// side-band delay line
	for (genvar k = 1; k <= OUT_TAP; k++) begin : g_side
		always_ff @(posedge clk) begin
			sb[k] <= sb[k-1];
		end
	end

	// wedge angle
	logic signed [CW-1:0] angle;
	logic signed [CW-1:0] ang_d [0:ANG_N-1];

	rff_cordic #(
		.FRAC_BITS(FRAC_BITS)
	) u_cordic (
		.clk  (clk),
		.dx   (dx_s3),
		.dy   (dy_s3),
		.angle(angle)
	);

	always_ff @(posedge clk) begin
		ang_d[0] <= angle;
	end

	for (genvar k = 1; k < ANG_N; k++) begin : g_ang
		always_ff @(posedge clk) begin
			ang_d[k] <= ang_d[k-1];
		end
	end

	// square root of the length squared, two bits a stage, one bit in the last
	sq_t sq_s [0:SQ_LAT];

	assign sq_s[0] = '{rem: {1'b0, lo_s3[SQR_W-1:0]}, root: '0};

	for (genvar g = 0; g < SQ_LAT; g++) begin : g_sqrt
		localparam int HI = MAG_W - 1 - 2 * g;
		sq_t sa, sb2;
		assign sa = sq_step(sq_s[g], HI);
		if (HI >= 1) begin : g_two
			assign sb2 = sq_step(sa, HI - 1);
		end else begin : g_one
			assign sb2 = sa;
		end
		always_ff @(posedge clk) begin
			sq_s[g+1] <= sb2;
		end
	end

	// offset times strength
	logic [REM_W-1:0] prod_x_s, prod_y_s;
	logic [MAG_W-1:0] m_s;
	logic [QUO_W-1:0] q_x, q_y;

	always_ff @(posedge clk) begin
		prod_x_s <= sb[SQ_LAT].mdx * sb[SQ_LAT].mst;
		prod_y_s <= sb[SQ_LAT].mdy * sb[SQ_LAT].mst;
		m_s      <= sq_s[SQ_LAT].root;
	end

	rff_div u_div_x (
		.clk     (clk),
		.dividend(prod_x_s),
		.divisor (m_s),
		.quotient(q_x)
	);

	rff_div u_div_y (
		.clk     (clk),
		.dividend(prod_y_s),
		.divisor (m_s),
		.quotient(q_y)
	);

	// result selection
	logic signed [CW-1:0] lo_cx, lo_cy, ang_f;
	logic excl, disc_hit;
	side_t sf;
	logic done_q, hit_q;
	logic signed [COORD_W-1:0] push_x_q, push_y_q;

	assign sf       = sb[OUT_TAP];
	assign ang_f    = ang_d[ANG_N-1];
	assign lo_cx    = {{(CW - COORD_W){sf.cx[COORD_W-1]}}, sf.cx};
	assign lo_cy    = {{(CW - COORD_W){sf.cy[COORD_W-1]}}, sf.cy};
	assign excl     = (lo_cx > ang_f) && (ang_f > lo_cy);
	assign disc_hit = sf.is_disc && sf.rad_ok && !excl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld[OUT_TAP+2];
		end
	end

	always_ff @(posedge clk) begin
		hit_q    <= (sf.is_box && sf.box_in) || disc_hit;
		push_x_q <= '0;
		push_y_q <= '0;
		if (sf.is_box && sf.box_in) begin
			push_x_q <= sf.cx;
			push_y_q <= sf.cy;
		end else if (disc_hit && !sf.zero) begin
			push_x_q <= sat(q_x, sf.neg_x);
			push_y_q <= sat(q_y, sf.neg_y);
		end
	end

	assign done   = done_q;
	assign hit    = hit_q;
	assign push_x = push_x_q;
	assign push_y = push_y_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction did not produce a result on time");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (push_x == '0 && push_y == '0))
		else $error("nonzero push on a miss");
`endif

endmodule

/* tb/region_force_field_tb.sv */
// region_force_field_tb: self-checking bench for region_force_field, box and wedge objects.
// Depends on rff_pkg for the kind codes, the cordic angle table and pi in Q2.30.
module region_force_field_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rff_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;

	localparam logic signed [31:0] MX = 32'sh7fffffff, MN = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] px, py, ax, ay, bx, by, cx, cy, st;
	} object_t;

	typedef struct {
		logic signed [31:0] fx, fy;
		logic               hit;
	} force_t;

	typedef struct {
		object_t obj;
		bit      known;
		force_t  want;
	} stim_row_t;

	logic clk, arst_n, start, busy, done, hit;
	logic [1:0] kind;
	logic signed [31:0] pos_x, pos_y, shape_a_x, shape_a_y, shape_b_x, shape_b_y;
	logic signed [31:0] shape_c_x, shape_c_y, strength, push_x, push_y;

	force_t    force_queue[$];
	stim_row_t stim_table[$];
	int        error_cnt = 0;
	int        idle_cycles = 0;

	region_force_field dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .shape_a_x(shape_a_x), .shape_a_y(shape_a_y),
		.shape_b_x(shape_b_x), .shape_b_y(shape_b_y), .shape_c_x(shape_c_x),
		.shape_c_y(shape_c_y), .strength(strength), .done(done), .push_x(push_x),
		.push_y(push_y), .hit(hit)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// arithmetic helpers for the force predictor
	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint shr_toward_zero(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// atan2 of the offset by cordic vectoring, rounded to 16 fraction bits
	function automatic longint offset_angle(longint x, longint y);
		longint z, xn, yn, pi_q;
		longint unsigned rm;
		pi_q = longint'(PI_Q30);
		if (y == 0)
			return x < 0 ? shr_toward_zero(pi_q + (64'sd1 <<< 13), 14) : 0;
		z = 0;
		while (mag(x) < (64'd1 << 29) && mag(y) < (64'd1 << 29)) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			z = (y >= 0) ? pi_q : -pi_q;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				xn = x + shr_toward_zero(y, i);
				yn = y - shr_toward_zero(x, i);
				z = z + longint'(ATAN_Q30[i]);
			end else begin
				xn = x - shr_toward_zero(y, i);
				yn = y + shr_toward_zero(x, i);
				z = z - longint'(ATAN_Q30[i]);
			end
			x = xn;
			y = yn;
		end
		rm = (mag(z) + (64'd1 << 13)) >> 14;
		return z < 0 ? -longint'(rm) : longint'(rm);
	endfunction

	// offset times strength over magnitude, truncated and saturated
	function automatic logic signed [31:0] scale_push(longint d, longint f, longint unsigned m);
		longint unsigned q;
		q = mag(d) * mag(f) / m;
		if ((d < 0) != (f < 0))
			return q > 64'd2147483648 ? 32'sh80000000 : 32'(-longint'(q));
		return q > 64'd2147483647 ? 32'sh7fffffff : 32'(q);
	endfunction

	function automatic force_t predict_force(object_t o);
		force_t r;
		longint dx, dy, ang;
		longint unsigned dx2, dy2, sum, m;
		bit wrap, ok_in, ok_out;
		r = '{fx: 0, fy: 0, hit: 1'b0};
		if (o.kind == KIND_BOX) begin
			if (o.px > o.ax && o.px < o.bx && o.py > o.ay && o.py < o.by)
				r = '{fx: o.cx, fy: o.cy, hit: 1'b1};
		end else if (o.kind == KIND_DISC) begin
			dx = longint'(o.px) - longint'(o.ax);
			dy = longint'(o.py) - longint'(o.ay);
			dx2 = mag(dx) * mag(dx);
			dy2 = mag(dy) * mag(dy);
			sum = dx2 + dy2;
			wrap = sum < dx2;
			ok_in = (o.bx < 0) || wrap || sum > mag(o.bx) * mag(o.bx);
			ok_out = (o.by > 0) && !wrap && sum < mag(o.by) * mag(o.by);
			if (ok_in && ok_out) begin
				ang = offset_angle(dx, dy);
				if (!(longint'(o.cx) > ang && ang > longint'(o.cy))) begin
					m = floor_root(sum);
					r.hit = 1'b1;
					if (m != 0) begin
						r.fx = scale_push(dx, o.st, m);
						r.fy = scale_push(dy, o.st, m);
					end
				end
			end
		end
		return r;
	endfunction

	// signed random value of about k significant bits
	function automatic logic signed [31:0] rand_bits(int k);
		return $signed($urandom) >>> (31 - k);
	endfunction

	// random object: mostly well-formed boxes and wedges, some raw noise
	function automatic object_t random_object();
		object_t o;
		int k, sel;
		logic signed [31:0] t;
		o.kind = 2'($urandom_range(0, 3));
		{o.px, o.py, o.ax, o.ay} = {$urandom, $urandom, $urandom, $urandom};
		{o.bx, o.by, o.cx, o.cy, o.st} = {$urandom, $urandom, $urandom, $urandom, $urandom};
		sel = $urandom_range(0, 9);
		k = $urandom_range(0, 28);
		if (sel < 3) begin
			o.kind = KIND_BOX;
			o.ax = rand_bits(30) - rand_bits(k);
			o.bx = o.ax + (rand_bits(k) & 32'sh7fffffff) + 1;
			o.ay = rand_bits(30) - rand_bits(k);
			o.by = o.ay + (rand_bits(k) & 32'sh7fffffff) + 1;
			o.px = o.ax + (rand_bits(k + 1) & 32'sh7fffffff);
			o.py = o.ay + (rand_bits(k + 1) & 32'sh7fffffff);
		end else if (sel < 8) begin
			o.kind = KIND_DISC;
			o.ax = rand_bits(30);
			o.ay = rand_bits(30);
			o.px = o.ax + rand_bits(k);
			o.py = o.ay + rand_bits(k);
			if ($urandom_range(0, 3) == 0)
				o.py = o.ay;
			o.bx = ($urandom_range(0, 4) == 0) ? -rand_bits(k) : (rand_bits(k) & 32'sh7fffffff);
			o.by = ($urandom_range(0, 5) == 0) ? rand_bits(k) : (rand_bits(k + 2) & 32'sh7fffffff);
			o.cx = rand_bits(19);
			o.cy = rand_bits(19);
			if ($urandom_range(0, 1) == 0) begin
				t = o.cx;
				o.cx = o.cy;
				o.cy = t;
			end
			o.st = rand_bits($urandom_range(0, 31));
		end
		return o;
	endfunction

	function automatic object_t make_obj(logic [1:0] kd, logic signed [31:0] px, py, ax, ay,
	                                     bx, by, cx, cy, st);
		return '{kind: kd, px: px, py: py, ax: ax, ay: ay, bx: bx, by: by,
		         cx: cx, cy: cy, st: st};
	endfunction

	// append one row to the stimulus table
	function automatic void add_row(object_t o, bit known, force_t want);
		stim_row_t row;
		row = '{obj: o, known: known, want: want};
		stim_table.insert(stim_table.size(), row);
	endfunction

	// directed rows: extremes, both kinds, unused kind, edge and exact-angle cases
	initial begin
		add_row(make_obj(KIND_NONE, MX, MX, MX, MX, MX, MX, MX, MX, MX), 1, '{0, 0, 0});
		add_row(make_obj(2'd3, MN, MN, MN, MN, MN, MN, MN, MN, MN), 1, '{0, 0, 0});
		add_row(make_obj(KIND_BOX, 0, 0, -100, -100, 100, 100, MX, MN, MX), 1, '{MX, MN, 1});
		add_row(make_obj(KIND_BOX, -100, 0, -100, -100, 100, 100, 5, 5, 0), 1, '{0, 0, 0});
		add_row(make_obj(KIND_BOX, 0, 0, MN, MN, MX, MX, -1, 1, 0), 1, '{-1, 1, 1});
		add_row(make_obj(KIND_BOX, MX, MN, MN, MN, MX, MX, 3, 3, 0), 1, '{0, 0, 0});
		// point on the centre with negative inner radius: hit with zero push
		add_row(make_obj(KIND_DISC, 77, -9, 77, -9, -1, ONE, 0, 0, MX), 1, '{0, 0, 1});
		// nonpositive outer radius never hits
		add_row(make_obj(KIND_DISC, ONE, 0, 0, 0, -1, 0, 0, 0, MX), 1, '{0, 0, 0});
		// offset straight to the left, angle exactly pi, inside the excluded window
		add_row(make_obj(KIND_DISC, -ONE, 0, 0, 0, 0, 2 * ONE, MX, 0, ONE), 1, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, -ONE, 0, 0, 0, 0, 2 * ONE, 0, 0, ONE), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, ONE, ONE, 0, 0, 0, 4 * ONE, 0, 0, MX), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, 3, -1, 0, 0, -1, 100, 0, 0, MN), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, MX, MX, MN, MN, MN, MX, 0, 0, MX), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, MX, 0, MN, 0, MN, MX, 0, 0, MN), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, 0, MN, 0, MX, MN, MX, MN, MX, 12345), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, -5, -7, 0, 0, MN, MX, ONE, -ONE, ONE), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, 0, ONE, 0, 0, 0, MX, 2 * ONE, ONE, ONE), 0, '{0, 0, 0});
		add_row(make_obj(KIND_DISC, 0, -ONE, 0, 0, 0, MX, -ONE, -2 * ONE, -ONE), 0,
			'{0, 0, 0});
	end

	// present one transaction and hold it until accepted
	task automatic send_object(object_t o, force_t want);
		start <= 1'b1;
		kind <= o.kind;
		pos_x <= o.px;
		pos_y <= o.py;
		shape_a_x <= o.ax;
		shape_a_y <= o.ay;
		shape_b_x <= o.bx;
		shape_b_y <= o.by;
		shape_c_x <= o.cx;
		shape_c_y <= o.cy;
		strength <= o.st;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		force_queue.insert(force_queue.size(), want);
	endtask

	// stimulus
	initial begin
		object_t o;
		int idle_pct;
		start = 1'b0;
		kind = KIND_NONE;
		{pos_x, pos_y, shape_a_x, shape_a_y, shape_b_x, shape_b_y} = '0;
		{shape_c_x, shape_c_y, strength} = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_table[i])
			send_object(stim_table[i].obj, stim_table[i].known ? stim_table[i].want
			            : predict_force(stim_table[i].obj));
		// random phases with different sender idle rates
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 49 : (ph == 3) ? 19 : 0;
			for (int n = 0; n < 200; n++) begin
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
				o = random_object();
				send_object(o, predict_force(o));
			end
		end
		start <= 1'b0;
		wait (force_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result check against the oldest expected force
	always @(negedge clk) begin
		force_t w;
		if (arst_n && done) begin
			if (force_queue.size() == 0) begin
				$display("%0t: unexpected result push=(%0d,%0d) hit=%0d",
				         $realtime, push_x, push_y, hit);
				error_cnt++;
			end else begin
				w = force_queue.pop_front();
				if (push_x !== w.fx || push_y !== w.fy || hit !== w.hit) begin
					$display("%0t: expected push=(%0d,%0d) hit=%0d, actual push=(%0d,%0d) hit=%0d",
					         $realtime, w.fx, w.fy, w.hit, push_x, push_y, hit);
					error_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
